FILE: hw/rtl/serx_pkg.sv
// ----------------------------------------------------------------------------
// serx_pkg
// Shared widths, reset values, register indexes and control structs for the
// scanline edge run extractor.
// ----------------------------------------------------------------------------
package serx_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned CLS_W   = 3;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned SPC_W   = 9;
  localparam int unsigned SKP_W   = 4;
  localparam int unsigned IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MAX_SKIP = 2'd0;
  localparam logic [IDX_W-1:0] REG_SPACING  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd2;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd3;

  // register reset values and legal bounds
  localparam logic [SKP_W-1:0] RST_MAX_SKIP = 4'd1;
  localparam logic [SPC_W-1:0] RST_SPACING  = 9'd16;
  localparam logic [DIM_W-1:0] RST_WIDTH    = 12'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT   = 12'd480;
  localparam logic [DIM_W-1:0] DIM_MIN      = 12'd3;
  localparam logic [DIM_W-1:0] DIM_MAX      = 12'd2048;
  localparam logic [SPC_W-1:0] SPC_MIN      = 9'd2;
  localparam logic [SPC_W-1:0] SPC_MAX      = 9'd256;

  // scan position after reset
  localparam logic [COORD_W-1:0] RST_ROW = COORD_W'(RST_HEIGHT - 12'd1);
  localparam logic [COORD_W-1:0] RST_COL = COORD_W'(RST_SPACING[SPC_W-1:1]) - 11'd1;

  // pixel kinds seen by the controller
  localparam logic [1:0] KIND_BOTTOM = 2'd0;
  localparam logic [1:0] KIND_TOP    = 2'd1;
  localparam logic [1:0] KIND_MID    = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic [SPC_W-1:0] spacing;
    logic [SKP_W-1:0] max_skip;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       emit;
    logic       rescan_needed;
    logic       rescan_last;
    logic       slot_free;
  } stat_t;

  typedef struct packed {
    logic accept;
    logic step_commit;
    logic top_first;
    logic top_second;
    logic rescan_step;
  } cmd_t;

endpackage

FILE: hw/rtl/serx_ctrl.sv
// ----------------------------------------------------------------------------
// serx_ctrl
// Sequencer: takes a pixel, evaluates it, emits results and steps the rescan.
// ----------------------------------------------------------------------------
module serx_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  serx_pkg::stat_t stat,
  output serx_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_TOP2   = 2'd2;
  localparam logic [1:0] S_RESCAN = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        case (stat.kind)
          serx_pkg::KIND_BOTTOM: begin
            cmd.step_commit = 1'b1;
            state_nxt       = S_IDLE;
          end
          serx_pkg::KIND_TOP: begin
            if (stat.slot_free) begin
              cmd.top_first = 1'b1;
              state_nxt     = S_TOP2;
            end
          end
          serx_pkg::KIND_MID: begin
            if (!stat.emit) begin
              cmd.step_commit = 1'b1;
              state_nxt       = S_IDLE;
            end else if (stat.slot_free) begin
              cmd.step_commit = 1'b1;
              state_nxt       = stat.rescan_needed ? S_RESCAN : S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_TOP2: begin
        if (stat.slot_free) begin
          cmd.top_second = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RESCAN: begin
        cmd.rescan_step = 1'b1;
        if (stat.rescan_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/serx_datapath.sv
// ----------------------------------------------------------------------------
// serx_datapath
// Run state, recent-pixel buffer, debounce counter and result register.
// ----------------------------------------------------------------------------
module serx_datapath #(
  parameter int unsigned MAX_EDGES  = 32,
  parameter int unsigned SKIP_LIMIT = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  serx_pkg::cfg_t                    cfg,
  input  serx_pkg::cmd_t                    cmd,
  output serx_pkg::stat_t                   stat,
  input  logic [serx_pkg::CLS_W-1:0]        in_pixel_class,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [serx_pkg::COORD_W-1:0]      out_edge_x,
  output logic [serx_pkg::COORD_W-1:0]      out_edge_y,
  output logic [serx_pkg::CLS_W-1:0]        out_edge_class,
  output logic [serx_pkg::COORD_W-1:0]      out_run_length,
  output logic                              out_last_of_column,
  output logic                              out_last_of_frame
);

  localparam int unsigned CW  = serx_pkg::COORD_W;
  localparam int unsigned KW  = serx_pkg::CLS_W;
  localparam int unsigned DW  = serx_pkg::DIM_W;
  localparam int unsigned SW  = serx_pkg::SPC_W;
  localparam int unsigned MW  = $clog2(SKIP_LIMIT + 2);
  localparam int unsigned EW  = $clog2(MAX_EDGES);
  localparam int unsigned BAW = (SKIP_LIMIT > 1) ? $clog2(SKIP_LIMIT) : 1;
  localparam int unsigned BD  = 2 ** BAW;
  localparam int unsigned EDGE_CAP = MAX_EDGES - 1;

  function automatic logic [MW-1:0] count_step(input logic [MW-1:0] m,
                                               input logic [KW-1:0] pix,
                                               input logic [KW-1:0] run);
    logic [MW-1:0] res;
    if (pix != run) begin
      res = m + MW'(1);
    end else if (m != '0) begin
      res = m - MW'(1);
    end else begin
      res = m;
    end
    return res;
  endfunction

  // scan and run state
  logic [CW-1:0]  row_r, col_r, pend_y_r;
  logic [KW-1:0]  run_cls_r, pend_cls_r, pix_r;
  logic [MW-1:0]  mis_r, rs_left_r;
  logic [EW-1:0]  ecnt_r;
  logic           capped_r, fs_r, out_valid_r;
  logic [serx_pkg::SKP_W-1:0] skip_r;
  logic [BAW-1:0] q_r;
  logic [KW-1:0]  buf_r [BD];

  // output payload
  logic [CW-1:0]  ox_r, oy_r, olen_r;
  logic [KW-1:0]  ocls_r;
  logic           ocol_r, ofrm_r;

  // derived values
  logic [DW-1:0]  h_m1, h_m2;
  logic [CW-1:0]  first_col, edge_y;
  logic [DW-1:0]  y_w, next_col;
  logic signed [DW+1:0] bound;
  logic           is_bottom, is_top, fin, emit, cap_next;
  logic [MW-1:0]  m_next;
  logic [EW-1:0]  ecnt_inc;

  assign h_m1      = cfg.height - DW'(1);
  assign h_m2      = cfg.height - DW'(2);
  assign first_col = CW'(cfg.spacing[SW-1:1]) - CW'(1);
  assign is_bottom = fs_r || ({1'b0, row_r} >= h_m1);
  assign is_top    = (row_r == '0);

  assign m_next   = count_step(mis_r, pix_r, run_cls_r);
  assign emit     = !capped_r && (32'(m_next) > 32'(skip_r));
  assign y_w      = DW'(row_r) + DW'(m_next) - DW'(1);
  assign edge_y   = y_w[CW-1:0];
  assign ecnt_inc = ecnt_r + EW'(1);
  assign cap_next = 32'(ecnt_inc) >= 32'(EDGE_CAP);

  // final column test, signed since the bound may go below zero
  assign next_col = DW'(col_r) + DW'(cfg.spacing);
  assign bound    = $signed({2'b00, cfg.width}) - $signed((DW+2)'(cfg.spacing[SW-1:1]));
  assign fin      = $signed({2'b00, next_col}) >= bound;

  always_comb begin
    stat.kind          = is_bottom ? serx_pkg::KIND_BOTTOM :
                         (is_top ? serx_pkg::KIND_TOP : serx_pkg::KIND_MID);
    stat.emit          = emit;
    stat.rescan_needed = !cap_next && (m_next > MW'(1));
    stat.rescan_last   = (rs_left_r == MW'(1));
    stat.slot_free     = !out_valid_r || !out_stall;
  end

  // result load
  logic          ld;
  logic [CW-1:0] ld_y, ld_len;
  logic [KW-1:0] ld_cls;
  logic          ld_col, ld_frm;

  always_comb begin
    ld     = 1'b0;
    ld_y   = pend_y_r;
    ld_cls = pend_cls_r;
    ld_len = pend_y_r;
    ld_col = 1'b0;
    ld_frm = 1'b0;
    if (cmd.step_commit && !is_bottom && emit) begin
      ld     = 1'b1;
      ld_len = pend_y_r - edge_y;
    end else if (cmd.top_first) begin
      ld = 1'b1;
    end else if (cmd.top_second) begin
      ld     = 1'b1;
      ld_y   = '0;
      ld_cls = pix_r;
      ld_len = '0;
      ld_col = 1'b1;
      ld_frm = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= serx_pkg::RST_ROW;
      col_r       <= serx_pkg::RST_COL;
      run_cls_r   <= '0;
      mis_r       <= '0;
      ecnt_r      <= '0;
      pend_y_r    <= '0;
      pend_cls_r  <= '0;
      capped_r    <= 1'b0;
      skip_r      <= serx_pkg::RST_MAX_SKIP;
      rs_left_r   <= '0;
      q_r         <= '0;
      fs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // held while stalled, reloaded only when the slot is free
      out_valid_r <= ld || (out_valid_r && out_stall);
      if (cmd.accept) begin
        fs_r <= in_frame_start;
      end
      if (cmd.step_commit) begin
        if (is_bottom) begin
          if (fs_r) begin
            col_r <= first_col;
          end
          skip_r     <= cfg.max_skip;
          run_cls_r  <= pix_r;
          pend_y_r   <= h_m1[CW-1:0];
          pend_cls_r <= pix_r;
          ecnt_r     <= EW'(1);
          mis_r      <= '0;
          capped_r   <= 1'b0;
          row_r      <= h_m2[CW-1:0];
        end else begin
          row_r <= row_r - CW'(1);
          if (!capped_r) begin
            if (emit) begin
              pend_y_r   <= edge_y;
              pend_cls_r <= pix_r;
              run_cls_r  <= pix_r;
              mis_r      <= '0;
              ecnt_r     <= ecnt_inc;
              capped_r   <= cap_next;
              // rescan rows from just below the new edge down to this one
              q_r        <= edge_y[BAW-1:0] - BAW'(1);
              rs_left_r  <= m_next - MW'(1);
            end else begin
              mis_r <= m_next;
            end
          end
        end
      end
      if (cmd.top_second) begin
        col_r <= fin ? first_col : next_col[CW-1:0];
        row_r <= h_m1[CW-1:0];
      end
      if (cmd.rescan_step) begin
        mis_r     <= count_step(mis_r, buf_r[q_r], run_cls_r);
        q_r       <= q_r - BAW'(1);
        rs_left_r <= rs_left_r - MW'(1);
      end
    end
  end

  // payload and buffer, no reset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= in_pixel_class;
    end
    if (cmd.step_commit && !is_bottom) begin
      buf_r[row_r[BAW-1:0]] <= pix_r;
    end
    if (ld) begin
      ox_r   <= col_r;
      oy_r   <= ld_y;
      ocls_r <= ld_cls;
      olen_r <= ld_len;
      ocol_r <= ld_col;
      ofrm_r <= ld_frm;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_edge_x         = ox_r;
  assign out_edge_y         = oy_r;
  assign out_edge_class     = ocls_r;
  assign out_run_length     = olen_r;
  assign out_last_of_column = ocol_r;
  assign out_last_of_frame  = ofrm_r;

endmodule

FILE: hw/rtl/scanline_edge_run_extractor_unit.sv
// ----------------------------------------------------------------------------
// scanline_edge_run_extractor_unit
// Debounced colour-run edge extraction along vertical scanlines.
// ----------------------------------------------------------------------------
// Usage: classified pixels of each scanned column arrive on the in_ channel,
// bottom row first, one request per pixel; the unit counts rows and columns
// itself, and in_frame_start restarts at the bottom of the first column.
// Edges leave on the out_ channel, each once the next edge is known, with
// its run length; the top edge of a column carries run length 0 and the
// last_of_column flag, plus last_of_frame on the final column.
// Timing: a pixel is accepted, then evaluated; a declared edge is in the
// output register in the cycle after evaluation. Row 0 passes through a
// further state for its second result. A declared edge may be followed by a
// rescan of up to max_skip buffered rows, one row a cycle, through the
// single debounce counter.
// Reset: registers return to max_skip 1, spacing 16, width 640, height 480;
// the scan sits at the bottom of the first column, no result pending.
// Stall: a result waits in the output register while out_stall is high; a
// new pixel is still taken, but a pixel that must emit waits until the
// output register is free. cfg_ready is always high; write only when idle.
// ----------------------------------------------------------------------------
module scanline_edge_run_extractor_unit #(
  parameter int unsigned MAX_EDGES  = 32,
  parameter int unsigned SKIP_LIMIT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [serx_pkg::CLS_W-1:0]   in_pixel_class,
  input  logic                         in_frame_start,
  // edge results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [serx_pkg::COORD_W-1:0] out_edge_x,
  output logic [serx_pkg::COORD_W-1:0] out_edge_y,
  output logic [serx_pkg::CLS_W-1:0]   out_edge_class,
  output logic [serx_pkg::COORD_W-1:0] out_run_length,
  output logic                         out_last_of_column,
  output logic                         out_last_of_frame,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [serx_pkg::IDX_W-1:0]   cfg_index,
  input  logic [serx_pkg::DIM_W-1:0]   cfg_data
);

  localparam logic [serx_pkg::SKP_W-1:0] SKIP_CAP = serx_pkg::SKP_W'(SKIP_LIMIT);

  logic [serx_pkg::SKP_W-1:0] max_skip_r;
  logic [serx_pkg::SPC_W-1:0] spacing_r;
  logic [serx_pkg::DIM_W-1:0] width_r, height_r;
  logic                       cfg_wr;

  serx_pkg::cfg_t  cfg_eff;
  serx_pkg::cmd_t  cmd;
  serx_pkg::stat_t stat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_skip_r <= serx_pkg::RST_MAX_SKIP;
      spacing_r  <= serx_pkg::RST_SPACING;
      width_r    <= serx_pkg::RST_WIDTH;
      height_r   <= serx_pkg::RST_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_index)
        serx_pkg::REG_MAX_SKIP: max_skip_r <= cfg_data[serx_pkg::SKP_W-1:0];
        serx_pkg::REG_SPACING:  spacing_r  <= cfg_data[serx_pkg::SPC_W-1:0];
        serx_pkg::REG_WIDTH:    width_r    <= cfg_data;
        serx_pkg::REG_HEIGHT:   height_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // registers as used: saturated to their legal ranges
  always_comb begin
    cfg_eff.max_skip = (max_skip_r > SKIP_CAP) ? SKIP_CAP : max_skip_r;
    cfg_eff.spacing  = (spacing_r < serx_pkg::SPC_MIN) ? serx_pkg::SPC_MIN :
                       ((spacing_r > serx_pkg::SPC_MAX) ? serx_pkg::SPC_MAX : spacing_r);
    cfg_eff.width    = (width_r < serx_pkg::DIM_MIN) ? serx_pkg::DIM_MIN :
                       ((width_r > serx_pkg::DIM_MAX) ? serx_pkg::DIM_MAX : width_r);
    cfg_eff.height   = (height_r < serx_pkg::DIM_MIN) ? serx_pkg::DIM_MIN :
                       ((height_r > serx_pkg::DIM_MAX) ? serx_pkg::DIM_MAX : height_r);
  end

  serx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  serx_datapath #(
    .MAX_EDGES  (MAX_EDGES),
    .SKIP_LIMIT (SKIP_LIMIT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_eff),
    .cmd                (cmd),
    .stat               (stat),
    .in_pixel_class     (in_pixel_class),
    .in_frame_start     (in_frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_edge_x         (out_edge_x),
    .out_edge_y         (out_edge_y),
    .out_edge_class     (out_edge_class),
    .out_run_length     (out_run_length),
    .out_last_of_column (out_last_of_column),
    .out_last_of_frame  (out_last_of_frame)
  );

endmodule
